[hdl/tbcc_pkg.sv]
// Package: shared types, register map and constants of the convolutional encoder.
`timescale 1ns / 1ps
package tbcc_pkg;

  // Field widths of the channel payload and the configuration registers
  localparam int SYM_W    = 4;
  localparam int POLY_W   = 7;
  localparam int MEML_W   = 3;
  localparam int OUTC_W   = 3;
  localparam int NUM_POLY = 4;

  // Configuration port geometry
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int REGIDX_W = 3;

  // Register indexes
  localparam logic [REGIDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_MEMLEN = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_OUTCNT = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_POLY0  = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_POLY1  = 3'd4;
  localparam logic [REGIDX_W-1:0] REG_POLY2  = 3'd5;
  localparam logic [REGIDX_W-1:0] REG_POLY3  = 3'd6;

  // Framing modes
  localparam logic MODE_ZT = 1'b0;
  localparam logic MODE_TB = 1'b1;

  // Register reset values
  localparam logic [MEML_W-1:0] MEMLEN_RST = 3'd2;
  localparam logic [OUTC_W-1:0] OUTCNT_RST = 3'd2;
  localparam logic [POLY_W-1:0] POLY0_RST  = 7'd5;
  localparam logic [POLY_W-1:0] POLY1_RST  = 7'd7;
  localparam logic [POLY_W-1:0] POLY2_RST  = 7'd0;
  localparam logic [POLY_W-1:0] POLY3_RST  = 7'd0;

  // Effective configuration seen by the datapath
  typedef struct packed {
    logic                                mode;
    logic [MEML_W-1:0]                   eff_mem;
    logic [OUTC_W-1:0]                   eff_out;
    logic [NUM_POLY-1:0][POLY_W-1:0]     gen_poly;
  } cfg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_EMIT = 3'b100
  } seq_state_e;

endpackage

[hdl/tbcc_if.sv]
// Interfaces: message bit input channel and code symbol output channel.
`timescale 1ns / 1ps
interface tbcc_in_if;
  logic valid;
  logic ready;
  logic msg_bit;
  logic msg_last;

  modport source (output valid, output msg_bit, output msg_last, input ready);
  modport sink (input valid, input msg_bit, input msg_last, output ready);
endinterface

interface tbcc_out_if;
  import tbcc_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] code_symbol;
  logic             cw_last;
  logic             error;

  modport source (output valid, output code_symbol, output cw_last, output error,
                  input ready);
  modport sink (input valid, input code_symbol, input cw_last, input error,
                output ready);
endinterface

[hdl/tbcc_cfg.sv]
// Configuration registers behind an APB-style port, with saturated effective values.
`timescale 1ns / 1ps
module tbcc_cfg #(
  parameter int MaxMem = 6,
  parameter int MaxOut = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tbcc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tbcc_pkg::DATA_W-1:0]  pwdata,
  output logic [tbcc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output tbcc_pkg::cfg_t               cfg_o
);
  import tbcc_pkg::*;

  localparam int Lim = (MaxOut < NUM_POLY) ? MaxOut : NUM_POLY;

  logic                            mode_q;
  logic [MEML_W-1:0]               mem_len_q;
  logic [OUTC_W-1:0]               out_count_q;
  logic [NUM_POLY-1:0][POLY_W-1:0] poly_q;
  logic [REGIDX_W-1:0]             idx;
  logic                            wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_ZT;
      mem_len_q   <= MEMLEN_RST;
      out_count_q <= OUTCNT_RST;
      poly_q[0]   <= POLY0_RST;
      poly_q[1]   <= POLY1_RST;
      poly_q[2]   <= POLY2_RST;
      poly_q[3]   <= POLY3_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE:   mode_q      <= pwdata[0];
        REG_MEMLEN: mem_len_q   <= pwdata[MEML_W-1:0];
        REG_OUTCNT: out_count_q <= pwdata[OUTC_W-1:0];
        REG_POLY0:  poly_q[0]   <= pwdata[POLY_W-1:0];
        REG_POLY1:  poly_q[1]   <= pwdata[POLY_W-1:0];
        REG_POLY2:  poly_q[2]   <= pwdata[POLY_W-1:0];
        REG_POLY3:  poly_q[3]   <= pwdata[POLY_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MODE:   prdata = DATA_W'(mode_q);
      REG_MEMLEN: prdata = DATA_W'(mem_len_q);
      REG_OUTCNT: prdata = DATA_W'(out_count_q);
      REG_POLY0:  prdata = DATA_W'(poly_q[0]);
      REG_POLY1:  prdata = DATA_W'(poly_q[1]);
      REG_POLY2:  prdata = DATA_W'(poly_q[2]);
      REG_POLY3:  prdata = DATA_W'(poly_q[3]);
      default:    prdata = '0;
    endcase
  end

  // Saturate memory length and output count into their legal ranges
  always_comb begin
    cfg_o.mode     = mode_q;
    cfg_o.gen_poly = poly_q;
    if (mem_len_q == '0) begin
      cfg_o.eff_mem = MEML_W'(1);
    end else if (int'(mem_len_q) > MaxMem) begin
      cfg_o.eff_mem = MEML_W'(MaxMem);
    end else begin
      cfg_o.eff_mem = mem_len_q;
    end
    if (out_count_q == '0) begin
      cfg_o.eff_out = OUTC_W'(1);
    end else if (int'(out_count_q) > Lim) begin
      cfg_o.eff_out = OUTC_W'(Lim);
    end else begin
      cfg_o.eff_out = out_count_q;
    end
  end

endmodule

[hdl/tbcc_enc_unit.sv]
// Shared encoder step: forms the register value, the tap parities and the next state.
`timescale 1ns / 1ps
module tbcc_enc_unit #(
  parameter int MaxMem = 6
) (
  input  tbcc_pkg::cfg_t                cfg_i,
  input  logic [MaxMem-1:0]             st_i,
  input  logic                          bit_i,
  output logic [tbcc_pkg::SYM_W-1:0]    sym_o,
  output logic [MaxMem-1:0]             st_o
);
  import tbcc_pkg::*;

  localparam int RW = MaxMem + 1;
  localparam int EW = (RW > POLY_W) ? RW : POLY_W;

  logic [MaxMem-1:0]   mask;
  logic [RW-1:0]       r;
  logic [EW-1:0]       r_ext;
  logic [NUM_POLY-1:0] par;

  // State mask from the effective memory length
  always_comb begin
    for (int i = 0; i < MaxMem; i++) begin
      mask[i] = (i < int'(cfg_i.eff_mem));
    end
  end

  assign r     = {st_i & mask, bit_i} & {mask, 1'b1};
  assign r_ext = EW'(r);
  assign st_o  = r[MaxMem-1:0] & mask;

  // One parity per generator
  always_comb begin
    for (int p = 0; p < NUM_POLY; p++) begin
      par[p] = ^(EW'(cfg_i.gen_poly[p]) & r_ext);
    end
  end

  // Pack coded bit 0 into the top used position
  always_comb begin
    unique case (cfg_i.eff_out)
      3'd2:    sym_o = {2'b00, par[0], par[1]};
      3'd3:    sym_o = {1'b0, par[0], par[1], par[2]};
      3'd4:    sym_o = {par[0], par[1], par[2], par[3]};
      default: sym_o = {3'b000, par[0]};
    endcase
  end

endmodule

[hdl/tbcc_seq.sv]
// Sequencer: streaming path, bit buffer memory, tail-biting replay and output register.
`timescale 1ns / 1ps
module tbcc_seq #(
  parameter int MaxMem  = 6,
  parameter int MaxBits = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tbcc_pkg::cfg_t  cfg_i,
  tbcc_in_if.sink         in_i,
  tbcc_out_if.source      out_o
);
  import tbcc_pkg::*;

  localparam int CntW = $clog2(MaxBits + 1);
  localparam int AW   = $clog2(MaxBits);

  seq_state_e          state_q, state_d;
  logic [MaxMem-1:0]   shift_q, shift_d;
  logic [MaxMem-1:0]   hist_q, hist_d;
  logic [MaxMem-1:0]   enc_st_q, enc_st_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     len_q, len_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic [CntW-1:0]     len_new;
  logic                ovf_q, ovf_d;
  logic                rd_data_q;
  logic                mem [MaxBits];
  logic                mem_we;
  logic                stored;

  logic                out_valid_q, out_valid_d;
  logic [SYM_W-1:0]    sym_q, sym_d;
  logic                last_q, last_d;
  logic                err_q, err_d;
  logic                out_load;
  logic                out_free;

  logic                in_acc;
  logic [MaxMem-1:0]   eu_st;
  logic                eu_bit;
  logic [SYM_W-1:0]    eu_sym;
  logic [MaxMem-1:0]   eu_st_next;

  assign out_free  = ~out_valid_q | out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) & out_free;
  assign in_acc    = in_i.valid & in_i.ready;
  assign stored    = (cnt_q < CntW'(MaxBits));
  assign len_new   = stored ? cnt_q + CntW'(1) : cnt_q;

  // Shared encoder step: streaming bit while idle, buffered bit during replay
  assign eu_st  = (state_q == ST_IDLE) ? shift_q : enc_st_q;
  assign eu_bit = (state_q == ST_IDLE) ? in_i.msg_bit : rd_data_q;

  tbcc_enc_unit #(.MaxMem(MaxMem)) u_enc (
    .cfg_i (cfg_i),
    .st_i  (eu_st),
    .bit_i (eu_bit),
    .sym_o (eu_sym),
    .st_o  (eu_st_next)
  );

  // Control
  always_comb begin
    state_d  = state_q;
    shift_d  = shift_q;
    hist_d   = hist_q;
    enc_st_d = enc_st_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    idx_d    = idx_q;
    ovf_d    = ovf_q;
    mem_we   = 1'b0;
    out_load = 1'b0;
    sym_d    = sym_q;
    last_d   = last_q;
    err_d    = err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cfg_i.mode == MODE_ZT) begin
            out_load = 1'b1;
            sym_d    = eu_sym;
            last_d   = in_i.msg_last;
            err_d    = 1'b0;
            shift_d  = in_i.msg_last ? '0 : eu_st_next;
          end else begin
            if (stored) begin
              mem_we = 1'b1;
              cnt_d  = len_new;
              hist_d = MaxMem'({hist_q, in_i.msg_bit});
            end else begin
              ovf_d = 1'b1;
            end
            if (in_i.msg_last) begin
              cnt_d   = '0;
              ovf_d   = 1'b0;
              shift_d = '0;
              if (ovf_q | ~stored | (len_new < CntW'(cfg_i.eff_mem))) begin
                out_load = 1'b1;
                sym_d    = '0;
                last_d   = 1'b1;
                err_d    = 1'b1;
              end else begin
                len_d    = len_new;
                idx_d    = '0;
                enc_st_d = MaxMem'({hist_q, in_i.msg_bit});
                state_d  = ST_RD;
              end
            end
          end
        end
      end
      ST_RD: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          sym_d    = eu_sym;
          last_d   = (idx_q + CntW'(1) == len_q);
          err_d    = 1'b0;
          enc_st_d = eu_st_next;
          idx_d    = idx_q + CntW'(1);
          state_d  = (idx_q + CntW'(1) == len_q) ? ST_IDLE : ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_o.ready);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      shift_q     <= '0;
      hist_q      <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      len_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      shift_q     <= shift_d;
      hist_q      <= hist_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    enc_st_q <= enc_st_d;
    if (out_load) begin
      sym_q  <= sym_d;
      last_q <= last_d;
      err_q  <= err_d;
    end
  end

  // Bit buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[AW-1:0]] <= in_i.msg_bit;
    end
    if (state_q == ST_RD) begin
      rd_data_q <= mem[idx_q[AW-1:0]];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.code_symbol = sym_q;
  assign out_o.cw_last     = last_q;
  assign out_o.error       = err_q;

endmodule

[hdl/conv_encoder_zt_tailbiting_top.sv]
// Top level: rate 1/n convolutional encoder, zero-terminated or tail-biting.
// Zero-terminated: one bit per cycle while the output is free; symbol next cycle.
// Tail-biting: bits go one per cycle into the buffer while the output is free; the
// last bit starts a replay with a buffer read, then an encode, for each symbol.
// Length errors give their single result in the cycle after the last bit.
// Asynchronous active-low reset clears state, counters, config and output valid.
`timescale 1ns / 1ps
module conv_encoder_zt_tailbiting_top #(
  parameter int MAX_MEM  = 6,
  parameter int MAX_OUT  = 4,
  parameter int MAX_BITS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tbcc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tbcc_pkg::DATA_W-1:0]  pwdata,
  output logic [tbcc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  tbcc_in_if.sink                      in_i,
  tbcc_out_if.source                   out_o
);
  import tbcc_pkg::*;

  cfg_t cfg;

  // Configuration registers
  tbcc_cfg #(.MaxMem(MAX_MEM), .MaxOut(MAX_OUT)) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Encoder sequencer
  tbcc_seq #(.MaxMem(MAX_MEM), .MaxBits(MAX_BITS)) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

[test/testbench.sv]
// Testbench: self-checking stimulus and scoreboard for the convolutional encoder top level.
`timescale 1ns / 1ps
module testbench;
  import tbcc_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RST_CYCLES   = 10;
  localparam int SETTLE       = 8;
  localparam int DRAIN        = 40;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 96;
  localparam int MEM_MAX      = 6;
  localparam int SYM_MAX      = 4;
  localparam int BUF_DEPTH    = 64;

  // One code symbol transaction as seen on the output channel
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             err;
  } code_sym_t;

  // Encoder predictor plus queue of code symbols still owed by the block
  class enc_scoreboard;
    logic                mode;
    logic [MEML_W-1:0]   mem_len;
    logic [OUTC_W-1:0]   out_count;
    logic [POLY_W-1:0]   taps [NUM_POLY];
    logic [MEM_MAX-1:0]  shift_state;
    logic                msg_buf [BUF_DEPTH];
    int                  buf_fill;
    logic                overflow;
    code_sym_t           owed_syms [$];
    int                  mismatches;
    int                  checked;
    int                  tb_words;
    int                  len_errors;

    function new();
      mode        = MODE_ZT;
      mem_len     = MEMLEN_RST;
      out_count   = OUTCNT_RST;
      taps[0]     = POLY0_RST;
      taps[1]     = POLY1_RST;
      taps[2]     = POLY2_RST;
      taps[3]     = POLY3_RST;
      shift_state = '0;
      buf_fill    = 0;
      overflow    = 1'b0;
      mismatches  = 0;
      checked     = 0;
      tb_words    = 0;
      len_errors  = 0;
    endfunction

    function void set_reg(logic [REGIDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_MODE:   mode = value[0];
        REG_MEMLEN: mem_len = value[MEML_W-1:0];
        REG_OUTCNT: out_count = value[OUTC_W-1:0];
        REG_POLY0, REG_POLY1, REG_POLY2, REG_POLY3: begin
          taps[int'(idx - REG_POLY0)] = value[POLY_W-1:0];
        end
        default: ;
      endcase
    endfunction

    // Append one symbol to the tail of the owed queue
    function void owe(code_sym_t e);
      owed_syms.insert(owed_syms.size(), e);
    endfunction

    // Saturated memory length and symbol width
    function int mem_bits();
      if (mem_len < 1) return 1;
      if (mem_len > MEM_MAX) return MEM_MAX;
      return int'(mem_len);
    endfunction

    function int sym_bits();
      if (out_count < 1) return 1;
      if (out_count > SYM_MAX) return SYM_MAX;
      return int'(out_count);
    endfunction

    // Shift one bit into st and return the parity symbol, coded bit 0 in the top used bit
    function logic [SYM_W-1:0] encode(inout logic [MEM_MAX-1:0] st, input logic b,
                                      input int m, input int n);
      logic [MEM_MAX-1:0] mask;
      logic [MEM_MAX:0]   reg_val;
      logic [SYM_W-1:0]   sym;
      int                 i;
      mask    = MEM_MAX'((1 << m) - 1);
      reg_val = {st & mask, b};
      sym     = '0;
      for (i = 0; i < n; i++) begin
        sym = {sym[SYM_W-2:0], ^(taps[i] & reg_val)};
      end
      st = reg_val[MEM_MAX-1:0] & mask;
      return sym;
    endfunction

    // Accepted message bit: work out the code symbols it releases
    function void note_bit(logic b, logic last);
      int                 m;
      int                 n;
      int                 j;
      logic [MEM_MAX-1:0] st;
      code_sym_t          e;
      m = mem_bits();
      n = sym_bits();
      if (mode == MODE_ZT) begin
        e.symbol = encode(shift_state, b, m, n);
        e.last   = last;
        e.err    = 1'b0;
        owe(e);
        if (last) shift_state = '0;
        return;
      end
      if (buf_fill < BUF_DEPTH) begin
        msg_buf[buf_fill] = b;
        buf_fill++;
      end else begin
        overflow = 1'b1;
      end
      if (!last) return;
      tb_words++;
      if (overflow || buf_fill < m) begin
        e.symbol = '0;
        e.last   = 1'b1;
        e.err    = 1'b1;
        owe(e);
        len_errors++;
      end else begin
        // start state is the message tail, newest bit in the LSB
        st = '0;
        for (j = 0; j < m; j++) begin
          st = {st[MEM_MAX-2:0], msg_buf[buf_fill - m + j]};
        end
        for (j = 0; j < buf_fill; j++) begin
          e.symbol = encode(st, msg_buf[j], m, n);
          e.last   = (j + 1 == buf_fill);
          e.err    = 1'b0;
          owe(e);
        end
      end
      buf_fill    = 0;
      overflow    = 1'b0;
      shift_state = '0;
    endfunction

    // Accepted code symbol: compare with the oldest owed one
    function void check(code_sym_t got);
      code_sym_t want;
      if (owed_syms.size() == 0) begin
        $error("code symbol %0h (cw_last %0b, error %0b) with nothing expected",
               got.symbol, got.last, got.err);
        mismatches++;
        return;
      end
      want = owed_syms.pop_front();
      checked++;
      if (got.symbol !== want.symbol) begin
        $error("code_symbol: expected %0h, got %0h", want.symbol, got.symbol);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("cw_last: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
      if (got.err !== want.err) begin
        $error("error: expected %0b, got %0b", want.err, got.err);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tbcc_in_if  in_ch ();
  tbcc_out_if out_ch ();

  enc_scoreboard sb = new();
  int            bits_sent = 0;
  int            settings = 0;
  bit            no_gaps = 1'b0;
  bit            hold_req = 1'b0;

  conv_encoder_zt_tailbiting_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // APB write: setup cycle, then access cycle until pready
  task automatic reg_write(logic [REGIDX_W-1:0] idx, logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Quiesce the input and let every owed symbol come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.owed_syms.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_mode(logic md);
    wait_idle();
    reg_write(REG_MODE, DATA_W'(md));
  endtask

  task automatic set_config(logic md, logic [MEML_W-1:0] mem, logic [OUTC_W-1:0] outc,
                            logic [POLY_W-1:0] p0, logic [POLY_W-1:0] p1,
                            logic [POLY_W-1:0] p2, logic [POLY_W-1:0] p3);
    wait_idle();
    reg_write(REG_MODE, DATA_W'(md));
    reg_write(REG_MEMLEN, DATA_W'(mem));
    reg_write(REG_OUTCNT, DATA_W'(outc));
    reg_write(REG_POLY0, DATA_W'(p0));
    reg_write(REG_POLY1, DATA_W'(p1));
    reg_write(REG_POLY2, DATA_W'(p2));
    reg_write(REG_POLY3, DATA_W'(p3));
    settings++;
  endtask

  // One message bit transaction, with an optional gap in front
  task automatic send_bit(logic b, logic last);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.msg_bit  <= b;
    in_ch.msg_last <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_bit(b, last);
    bits_sent++;
  endtask

  // Bits go out LSB first; close marks the final one as the message end
  task automatic send_word(logic [63:0] pattern, int len, logic close);
    int i;
    for (i = 0; i < len; i++) begin
      send_bit(pattern[i % 64], close && (i == len - 1));
    end
  endtask

  task automatic run_directed();
    // streaming with reset settings, then a single-bit message
    send_word(64'b1101, 4, 1'b1);
    send_word(64'b1, 1, 1'b1);
    // open streaming message left behind, tail-biting takes over
    send_word(64'b11, 2, 1'b0);
    set_config(MODE_TB, 3'd2, 3'd3, 7'h05, 7'h07, 7'h03, 7'h7F);
    send_word(64'b1, 1, 1'b1);          // shorter than the memory
    send_word(64'b11, 2, 1'b1);         // exactly the memory length
    send_word(64'b10110, 5, 1'b1);
    // mode switched twice in the middle of a buffered message
    send_word(64'b101, 3, 1'b0);
    set_mode(MODE_ZT);
    send_word(64'b01, 2, 1'b0);
    set_mode(MODE_TB);
    send_word(64'b11, 2, 1'b1);
    set_mode(MODE_ZT);
    send_word(64'b1, 1, 1'b1);
    // saturation: memory and width below and above their ranges
    set_config(MODE_ZT, 3'd0, 3'd0, 7'h7F, 7'h00, 7'h7F, 7'h00);
    send_word(64'b10, 2, 1'b1);
    set_config(MODE_TB, 3'd7, 3'd7, 7'h7F, 7'h40, 7'h55, 7'h2A);
    send_word(64'b1011001, 7, 1'b1);
  endtask

  // One register setting and a few messages with random content
  task automatic run_random_phase(int phase_no);
    logic md;
    int   m;
    int   len;
    int   k;
    int   msgs;
    if (phase_no == 1) md = MODE_ZT;
    else if (phase_no == 2) md = MODE_TB;
    else md = logic'($urandom_range(0, 1));
    set_config(md, MEML_W'($urandom_range(0, 7)), OUTC_W'($urandom_range(0, 7)),
               POLY_W'($urandom_range(0, 127)), POLY_W'($urandom_range(0, 127)),
               POLY_W'($urandom_range(0, 127)), POLY_W'($urandom_range(0, 127)));
    if (phase_no == 1) begin
      // receiver holds off while bits keep coming back to back
      hold_req = 1'b1;
      no_gaps  = 1'b1;
      for (k = 0; k < 3; k++) send_word({$urandom, $urandom}, 4, 1'b1);
    end else if (phase_no == 2) begin
      // overlong: buffer fills, then bits are dropped
      send_word({$urandom, $urandom}, BUF_DEPTH + 2, 1'b1);
      send_word({$urandom, $urandom}, 8, 1'b1);
    end else begin
      no_gaps = ($urandom_range(0, 3) == 0);
      msgs    = $urandom_range(1, 2);
      for (k = 0; k < msgs; k++) begin
        m = sb.mem_bits();
        if (md == MODE_ZT) len = $urandom_range(1, 12);
        else if (m > 1 && $urandom_range(0, 9) == 0) len = $urandom_range(1, m - 1);
        else len = $urandom_range(m, m + 10);
        send_word({$urandom, $urandom}, len, 1'b1);
      end
    end
    no_gaps = 1'b0;
  endtask

  // Stimulus and end of run
  initial begin
    int phase_no;
    int target;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.msg_bit  = 1'b0;
    in_ch.msg_last = 1'b0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    target   = bits_sent + RANDOM_ITEMS;
    phase_no = 1;
    while (bits_sent < target) begin
      run_random_phase(phase_no);
      phase_no++;
    end
    wait_idle();
    repeat (DRAIN) @(posedge clk_i);
    $display("Covered %0d message bits and %0d code symbols over %0d register settings;",
             bits_sent, sb.checked, settings);
    $display("%0d tail-biting codewords, %0d of them length errors.",
             sb.tb_words, sb.len_errors);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Output side: random back-pressure, steady stretches and one long hold
  initial begin
    int        stall;
    int        steady;
    code_sym_t got;
    out_ch.ready = 1'b0;
    steady       = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end else if (steady > 0) begin
        steady--;
        stall = 0;
      end else if ($urandom_range(0, 39) == 0) begin
        steady = 30;
        stall  = 0;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      got.symbol = out_ch.code_symbol;
      got.last   = out_ch.cw_last;
      got.err    = out_ch.error;
      sb.check(got);
    end
  end

  // Watchdog: too long without any transaction or register access
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: %0d cycles without progress", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
hdl/tbcc_pkg.sv
hdl/tbcc_if.sv
hdl/tbcc_cfg.sv
hdl/tbcc_enc_unit.sv
hdl/tbcc_seq.sv
hdl/conv_encoder_zt_tailbiting_top.sv
test/testbench.sv
